/* design/wav_pcm_to_stereo_frames_defines.svh */
// Assertion macros used by the top-level design file.
`ifndef WAV_PCM_TO_STEREO_FRAMES_DEFINES_SVH
`define WAV_PCM_TO_STEREO_FRAMES_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define WPS_ASSERT_IMPLY(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define WPS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants of the WAV PCM to stereo frame converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package wps_pkg;
    localparam int HEADER_BYTES  = 44;
    localparam int CAPTURE_BYTES = 8;
    localparam logic [1:0] ST_FRAME = 2'd0;
    localparam logic [1:0] ST_MARK  = 2'd1;
    localparam logic [1:0] ST_RATE  = 2'd2;
    localparam logic [1:0] ST_ALIGN = 2'd3;
    localparam logic [15:0] FMT_FLOAT = 16'd3;
    localparam logic [0:0] CFG_RATE = 1'b0;
    localparam logic [0:0] CFG_GAIN = 1'b1;
    localparam logic [23:0] FLOAT_SCALE = 24'd8388607;

    typedef struct packed {
        logic [63:0] bytes;
        logic [1:0]  status;
        logic        last;
        logic [1:0]  bps;     // 0 none, 1 two, 2 three, 3 four bytes
        logic        is_float;
        logic        mono;
    } job_t;
endpackage

/* design/wps_if.sv */
// ----------------------------------------------------------------------------
// wps_if
// Generic valid/ready stream interface with a payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface wps_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* design/wav_pcm_to_stereo_frames.sv */
// A frame word enters the front's job register once its last byte is taken; the decoder
// takes it in S_IDLE, then S_MUL, S_SAT, S_OUT (mono float: S_MUL, S_SAT twice). Error words
// follow the same path once header byte 43 is taken. Throughput: one byte per cycle while
// in_ready is high; input stalls while a finished word waits in the hand-off register.
// Reset: asynchronous, active low; parser back to header phase, state and config registers to defaults.
// ----------------------------------------------------------------------------
// wav_pcm_to_stereo_frames
// WAV byte stream to stereo frame converter: parser front, decoder back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wav_pcm_to_stereo_frames_defines.svh"
module wav_pcm_to_stereo_frames (
    input  logic clk,
    input  logic rst_n,
    wps_if.sink   in_ch,
    wps_if.sink   cfg,
    wps_if.source out_ch
);
    // in_ch.data = {file_start, data_byte}; cfg.data = {index, value[31:0]}
    // out_ch.data = {last_frame, status, right_sample, left_sample}
    logic [31:0] rate_reg;
    logic [15:0] gain_reg;
    logic        jv, jr;
    wps_pkg::job_t job;
    logic [31:0] ls, rs;
    logic [1:0]  st;
    logic        lf;

    // Accept configuration words at any time.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 32'd44100;
            gain_reg <= 16'd46341;
        end
        else if (cfg.valid)
        begin
            if (cfg.data[32] == wps_pkg::CFG_RATE) rate_reg <= cfg.data[31:0];
            else gain_reg <= cfg.data[15:0];
        end
    end

    wps_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .data_byte(in_ch.data[7:0]), .file_start(in_ch.data[8]),
        .accepted_rate(rate_reg), .job_valid(jv), .job_ready(jr), .job(job)
    );

    wps_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(job),
        .mono_gain(gain_reg), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .left_sample(ls), .right_sample(rs), .status(st), .last_frame(lf)
    );

    assign out_ch.data = {lf, st, rs, ls};

    // Error words always carry last_frame and a zero left sample.
    `WPS_ASSERT_IMPLY(a_err_last, out_ch.valid && st != wps_pkg::ST_FRAME, lf && ls == 32'd0)
    // A stalled result holds its payload.
    `WPS_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, $stable(out_ch.data))
endmodule

/* design/wps_front.sv */
// ----------------------------------------------------------------------------
// wps_front
// Header parser and frame collector; emits one job per result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                file_start,
    input  logic [31:0]         accepted_rate,
    output logic                job_valid,
    input  logic                job_ready,
    output wps_pkg::job_t       job
);
    typedef enum logic [2:0] {PH_HEADER = 3'b001, PH_DATA = 3'b010, PH_DONE = 3'b100} ph_t;
    ph_t         phase_reg, phase_next;
    logic [5:0]  off_reg, off_next;
    logic        ok_reg, ok_next;
    logic [15:0] fmt_reg, fmt_next, ch_reg, ch_next, stride_reg, stride_next;
    logic [15:0] bits_reg, bits_next, idx_reg, idx_next;
    logic [31:0] rate_reg, rate_next, left_reg, left_next;
    logic [63:0] fb_reg, fb_next;
    logic        jv_reg, jv_next;
    wps_pkg::job_t job_reg, job_next;

    logic        acc;
    ph_t         ph;
    logic [5:0]  off;
    logic [15:0] idx1, bpsw;

    assign in_ready  = !jv_reg || job_ready;
    assign acc       = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_comb
    begin
        phase_next = phase_reg; off_next = off_reg; ok_next = ok_reg;
        fmt_next = fmt_reg; ch_next = ch_reg; rate_next = rate_reg;
        stride_next = stride_reg; bits_next = bits_reg; left_next = left_reg;
        idx_next = idx_reg; fb_next = fb_reg;
        jv_next = jv_reg && !job_ready; job_next = job_reg;
        idx1 = 16'd0; bpsw = 16'd0;
        ph = phase_reg; off = off_reg;
        if (acc)
        begin
            if (file_start)
            begin
                ph = PH_HEADER; off = 6'd0; ok_next = 1'b1;
                fmt_next = '0; ch_next = '0; rate_next = '0; stride_next = '0;
                bits_next = '0; left_next = '0; idx_next = '0; fb_next = '0;
            end
            phase_next = ph;
            unique case (ph)
                PH_HEADER:
                begin
                    case (off)
                        6'd0: if (data_byte != 8'h52) ok_next = 1'b0;
                        6'd1: if (data_byte != 8'h49) ok_next = 1'b0;
                        6'd2, 6'd3: if (data_byte != 8'h46) ok_next = 1'b0;
                        6'd8: if (data_byte != 8'h57) ok_next = 1'b0;
                        6'd9: if (data_byte != 8'h41) ok_next = 1'b0;
                        6'd10: if (data_byte != 8'h56) ok_next = 1'b0;
                        6'd11: if (data_byte != 8'h45) ok_next = 1'b0;
                        6'd20: fmt_next[7:0] = data_byte;
                        6'd21: fmt_next[15:8] = data_byte;
                        6'd22: ch_next[7:0] = data_byte;
                        6'd23: ch_next[15:8] = data_byte;
                        6'd24: rate_next[7:0] = data_byte;
                        6'd25: rate_next[15:8] = data_byte;
                        6'd26: rate_next[23:16] = data_byte;
                        6'd27: rate_next[31:24] = data_byte;
                        6'd32: stride_next[7:0] = data_byte;
                        6'd33: stride_next[15:8] = data_byte;
                        6'd34: bits_next[7:0] = data_byte;
                        6'd35: bits_next[15:8] = data_byte;
                        6'd40: left_next[7:0] = data_byte;
                        6'd41: left_next[15:8] = data_byte;
                        6'd42: left_next[23:16] = data_byte;
                        6'd43: left_next[31:24] = data_byte;
                        default: ;
                    endcase
                    off_next = off + 6'd1;
                    if (off == 6'(wps_pkg::HEADER_BYTES - 1))
                    begin
                        phase_next = PH_DONE;
                        job_next = '0; job_next.last = 1'b1;
                        if (!ok_next) job_next.status = wps_pkg::ST_MARK;
                        else if (rate_next != accepted_rate) job_next.status = wps_pkg::ST_RATE;
                        else if (stride_next == 16'd0) job_next.status = wps_pkg::ST_ALIGN;
                        if (job_next.status != wps_pkg::ST_FRAME) jv_next = 1'b1;
                        else if (left_next >= {16'd0, stride_next}) phase_next = PH_DATA;
                        idx_next = '0; fb_next = '0;
                    end
                end
                PH_DATA:
                begin
                    if (idx_reg < 16'(wps_pkg::CAPTURE_BYTES))
                        fb_next[8*idx_reg[2:0] +: 8] = data_byte;
                    idx1 = idx_reg + 16'd1;
                    idx_next = idx1;
                    left_next = left_reg - 32'd1;
                    if (idx1 != stride_reg)
                    begin
                        if (left_next == 32'd0) phase_next = PH_DONE;
                    end
                    else
                    begin
                        bpsw = bits_reg >> 3;
                        job_next.bytes = fb_next;
                        job_next.status = wps_pkg::ST_FRAME;
                        job_next.last = left_next < {16'd0, stride_reg};
                        job_next.is_float = fmt_reg == wps_pkg::FMT_FLOAT;
                        job_next.mono = ch_reg == 16'd1;
                        case (bpsw)
                            16'd2: job_next.bps = 2'd1;
                            16'd3: job_next.bps = 2'd2;
                            16'd4: job_next.bps = 2'd3;
                            default: job_next.bps = 2'd0;
                        endcase
                        jv_next = 1'b1;
                        if (job_next.last) phase_next = PH_DONE;
                        idx_next = '0; fb_next = '0;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; off_reg <= '0; ok_reg <= 1'b1;
            fmt_reg <= '0; ch_reg <= '0; rate_reg <= '0; stride_reg <= '0;
            bits_reg <= '0; left_reg <= '0; idx_reg <= '0; fb_reg <= '0;
            jv_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; off_reg <= off_next; ok_reg <= ok_next;
            fmt_reg <= fmt_next; ch_reg <= ch_next; rate_reg <= rate_next;
            stride_reg <= stride_next; bits_reg <= bits_next; left_reg <= left_next;
            idx_reg <= idx_next; fb_reg <= fb_next; jv_reg <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule

/* design/wps_back.sv */
// ----------------------------------------------------------------------------
// wps_back
// Sample decoder: float scaling and mono gain over the S_MUL and S_SAT stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wps_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  wps_pkg::job_t  job,
    input  logic [15:0]    mono_gain,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    left_sample,
    output logic [31:0]    right_sample,
    output logic [1:0]     status,
    output logic           last_frame
);
    typedef enum logic [3:0] {S_IDLE = 4'b0001, S_MUL = 4'b0010, S_SAT = 4'b0100,
                              S_OUT = 4'b1000} st_t;
    st_t st_reg, st_next;
    wps_pkg::job_t j_reg, j_next;
    logic [47:0] pl_reg, pl_next, pr_reg, pr_next;
    logic [31:0] l_reg, l_next, r_reg, r_next;
    logic        nl_reg, nl_next, nr_reg, nr_next;
    logic        sl_reg, sl_next, sr_reg, sr_next; // float conversion flags
    logic [7:0]  sh_l_reg, sh_l_next, sh_r_reg, sh_r_next;

    function automatic logic [31:0] raw(input logic [63:0] b, input logic [2:0] at,
                                        input logic [1:0] bps);
        logic [63:0] s;
        logic [31:0] v;
        begin
            s = b >> {at, 3'b000};
            case (bps)
                2'd1: v = {{8{s[15]}}, s[15:0], 8'd0};
                2'd2: v = {{8{s[23]}}, s[23:0]};
                2'd3: v = s[31:0];
                default: v = '0;
            endcase
            raw = v;
        end
    endfunction

    function automatic logic [31:0] sgn(input logic neg, input logic [63:0] mag);
        begin
            if (neg) sgn = (mag > 64'h80000000) ? 32'h80000000 : 32'(0 - mag[31:0]);
            else sgn = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end
    endfunction

    function automatic logic [31:0] fcv(input logic neg, input logic [30:0] bits,
                                        input logic [47:0] prod, input logic [7:0] sh);
        logic signed [8:0] s;
        begin
            s = 9'sd150 - $signed({1'b0, (bits[30:23] == 8'd0) ? 8'd1 : bits[30:23]});
            if (bits[30:23] == 8'hFF)
                fcv = (bits[22:0] != 23'd0) ? 32'd0 : sgn(neg, 64'hFFFFFFFFFF);
            else if (s <= 0)
                fcv = (prod == 48'd0) ? 32'd0 : sgn(neg, 64'hFFFFFFFFFF);
            else if (s >= 9'sd64)
                fcv = 32'd0;
            else
                fcv = sgn(neg, 64'(prod) >> sh);
        end
    endfunction

    logic [2:0]  roff;
    logic [31:0] rl, rr, ml;
    assign roff = {1'b0, j_reg.bps} + 3'd1;
    assign rl = raw(j_reg.bytes, 3'd0, j_reg.bps);
    assign rr = raw(j_reg.bytes, roff, j_reg.bps);
    assign ml = rl[31] ? (32'd0 - rl) : rl;

    assign job_ready    = st_reg == S_IDLE;
    assign out_valid    = st_reg == S_OUT;
    assign left_sample  = l_reg;
    assign right_sample = r_reg;
    assign status       = j_reg.status;
    assign last_frame   = j_reg.last;

    always_comb
    begin
        st_next = st_reg; j_next = j_reg; pl_next = pl_reg; pr_next = pr_reg;
        l_next = l_reg; r_next = r_reg; nl_next = nl_reg; nr_next = nr_reg;
        sl_next = sl_reg; sr_next = sr_reg; sh_l_next = sh_l_reg; sh_r_next = sh_r_reg;
        unique case (st_reg)
            S_IDLE:
                if (job_valid)
                begin
                    j_next = job;
                    st_next = S_MUL;
                end
            S_MUL:
            begin
                // Stage one: form products.
                st_next = S_SAT;
                nl_next = rl[31]; nr_next = rr[31];
                sl_next = 1'b0; sr_next = 1'b0;
                if (j_reg.status != wps_pkg::ST_FRAME)
                begin
                    pl_next = '0; pr_next = '0; sh_l_next = 8'd0; sh_r_next = 8'd0;
                end
                else if (j_reg.mono)
                begin
                    // Float or int source magnitude goes through gain; float first.
                    pl_next = 48'(ml) * 48'(mono_gain);
                    sh_l_next = 8'd16;
                    pr_next = '0; sh_r_next = 8'd0;
                end
                else
                begin
                    pl_next = {16'd0, rl}; pr_next = {16'd0, rr};
                    sh_l_next = 8'd0; sh_r_next = 8'd0;
                end
                if (j_reg.status == wps_pkg::ST_FRAME && j_reg.bps == 2'd3 && j_reg.is_float)
                begin
                    // Float: mantissa times scale, exponent gives the shift.
                    pl_next = 48'({rl[30:23] != 8'd0, rl[22:0]}) * 48'(wps_pkg::FLOAT_SCALE);
                    pr_next = 48'({rr[30:23] != 8'd0, rr[22:0]}) * 48'(wps_pkg::FLOAT_SCALE);
                    sh_l_next = 8'd150 - ((rl[30:23] == 8'd0) ? 8'd1 : rl[30:23]);
                    sh_r_next = 8'd150 - ((rr[30:23] == 8'd0) ? 8'd1 : rr[30:23]);
                    sl_next = 1'b1; sr_next = 1'b1;
                end
            end
            S_SAT:
            begin
                st_next = S_OUT;
                if (sl_reg) l_next = fcv(nl_reg, j_reg.bytes[30:0], pl_reg, sh_l_reg);
                else if (j_reg.mono && j_reg.status == wps_pkg::ST_FRAME)
                    l_next = sgn(nl_reg, 64'(pl_reg >> 16));
                else l_next = pl_reg[31:0];
                if (sr_reg) r_next = fcv(nr_reg, rr[30:0], pr_reg, sh_r_reg);
                else r_next = pr_reg[31:0];
                if (j_reg.mono && j_reg.status == wps_pkg::ST_FRAME)
                begin
                    if (sl_reg)
                    begin
                        // Float mono: gain applies after conversion, redo gain pass.
                        j_next.is_float = 1'b0;
                        j_next.bps = 2'd3;
                        j_next.bytes[31:0] = fcv(nl_reg, j_reg.bytes[30:0], pl_reg, sh_l_reg);
                        st_next = S_MUL;
                    end
                    else r_next = l_next;
                end
            end
            S_OUT:
                if (out_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= S_IDLE;
        else st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next; pl_reg <= pl_next; pr_reg <= pr_next; l_reg <= l_next;
        r_reg <= r_next; nl_reg <= nl_next; nr_reg <= nr_next; sl_reg <= sl_next;
        sr_reg <= sr_next; sh_l_reg <= sh_l_next; sh_r_reg <= sh_r_next;
    end
endmodule
